// ===== design/multigrid_block_decomposer_defines.svh =====
// ----------------------------------------------------------------------------
// Multigrid block decomposer assertion macros
// Shared assertion forms for the controller and datapath checks.
// ----------------------------------------------------------------------------
`ifndef MULTIGRID_BLOCK_DECOMPOSER_DEFINES_SVH
`define MULTIGRID_BLOCK_DECOMPOSER_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define MGBD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle
`define MGBD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mgbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Multigrid block decomposer package
// Payload types, register indexes, dimension codes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mgbd_pkg;

   // Fixed field widths
   localparam int COORD_BITS     = 16;
   localparam int POS_BITS       = 10;
   localparam int DIM_BITS       = 2;
   localparam int CSR_INDEX_BITS = 3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROCS_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROCS_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROCS_Z = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POS_X   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POS_Y   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POS_Z   = 3'd5;

   // Dimension codes
   localparam logic [DIM_BITS-1:0] DIM_X = 2'd0;
   localparam logic [DIM_BITS-1:0] DIM_Y = 2'd1;
   localparam logic [DIM_BITS-1:0] DIM_Z = 2'd2;

   typedef struct packed {
      logic                  first_level;
      logic [COORD_BITS-1:0] size_x;
      logic [COORD_BITS-1:0] size_y;
      logic [COORD_BITS-1:0] size_z;
      logic [COORD_BITS-1:0] finer_lo_x;
      logic [COORD_BITS-1:0] finer_lo_y;
      logic [COORD_BITS-1:0] finer_lo_z;
      logic [COORD_BITS-1:0] finer_hi_x;
      logic [COORD_BITS-1:0] finer_hi_y;
      logic [COORD_BITS-1:0] finer_hi_z;
   } req_payload_type;

   typedef struct packed {
      logic [DIM_BITS-1:0]   dim;
      logic                  last;
      logic                  active;
      logic [COORD_BITS-1:0] local_begin;
      logic [COORD_BITS-1:0] local_end;
      logic [COORD_BITS-1:0] local_size;
      logic [COORD_BITS-1:0] local_finer_begin;
      logic [COORD_BITS-1:0] local_finer_end;
      logic [COORD_BITS-1:0] local_finer_size;
   } rsp_payload_type;

   typedef struct packed {
      logic                load;
      logic                div_start;
      logic                cnt_store;
      logic                mul;
      logic                sum;
      logic                emit;
      logic [DIM_BITS-1:0] dim;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic slot_free;
   } dp_status_type;

endpackage

// ===== design/mgbd_divider.sv =====
// ----------------------------------------------------------------------------
// Multigrid block decomposer serial divider
// Restoring unsigned divider, one quotient bit per cycle over a
// coordinate-wide dividend. Quotient and remainder hold after done.
// ----------------------------------------------------------------------------
module mgbd_divider import mgbd_pkg::*; #(
   parameter int DVS_BITS = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] dividend,
   input  logic [DVS_BITS-1:0]   divisor,
   output logic                  done,
   output logic [COORD_BITS-1:0] quotient,
   output logic [DVS_BITS-1:0]   remainder
);

   localparam int COUNT_BITS = $clog2(COORD_BITS);
   localparam logic [COUNT_BITS-1:0] COUNT_LAST = COUNT_BITS'(COORD_BITS - 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COORD_BITS-1:0] quo_ff, quo_in;
   logic [DVS_BITS-1:0]   rem_ff, rem_in;
   logic [DVS_BITS-1:0]   dvs_ff;
   logic [DVS_BITS:0]     rem_shift;
   logic                  fits;

   // Shift in one dividend bit and try a subtract
   always_comb begin
      rem_shift = {rem_ff, quo_ff[COORD_BITS-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      if (fits) begin
         rem_in = DVS_BITS'(rem_shift - {1'b0, dvs_ff});
      end else begin
         rem_in = rem_shift[DVS_BITS-1:0];
      end
      quo_in = {quo_ff[COORD_BITS-2:0], fits};
   end

   // Sequence the iterations
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == COUNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Load operands, then advance the partial results
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/mgbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Multigrid block decomposer controller
// Steps one level through the active counts, the split divisions and
// the per-dimension multiply, sum and emit stages.
// ----------------------------------------------------------------------------
`include "multigrid_block_decomposer_defines.svh"

module mgbd_ctrl import mgbd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_COUNT    = 3'd1;
   localparam logic [2:0] S_DIV_GO   = 3'd2;
   localparam logic [2:0] S_DIV_WAIT = 3'd3;
   localparam logic [2:0] S_MUL      = 3'd4;
   localparam logic [2:0] S_SUM      = 3'd5;
   localparam logic [2:0] S_EMIT     = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [DIM_BITS-1:0] dim_ff, dim_in;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      dim_in        = dim_ff;
      cmd           = '0;
      cmd.dim       = dim_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            cmd.cnt_store = 1'b1;
            state_in      = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               dim_in   = DIM_X;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               if (dim_ff == DIM_Z) begin
                  dim_in   = DIM_X;
                  state_in = S_IDLE;
               end else begin
                  dim_in   = dim_ff + 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and dimension
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dim_ff   <= DIM_X;
      end else begin
         state_ff <= state_in;
         dim_ff   <= dim_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   `MGBD_ASSERT_SAME(a_done_in_wait, status.div_done,
      state_ff == S_DIV_WAIT, "divider done outside the wait state")
   `MGBD_ASSERT_NEXT(a_z_ends_run, cmd.emit && dim_ff == DIM_Z,
      state_ff == S_IDLE && dim_ff == DIM_X, "run did not end after the z result")

endmodule

// ===== design/mgbd_datapath.sv =====
// ----------------------------------------------------------------------------
// Multigrid block decomposer datapath
// Configuration registers, the level register, three divider lanes, the
// range arithmetic, per-dimension history and the result register.
// ----------------------------------------------------------------------------
`include "multigrid_block_decomposer_defines.svh"

module mgbd_datapath import mgbd_pkg::*; #(
   parameter int PROC_BITS  = 11,
   parameter int MIN_POINTS = 5,
   parameter int CSR_BITS   = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]       csr_wdata,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  dp_cmd_type                cmd,
   output dp_status_type             status
);

   localparam int DVS_BITS  = PROC_BITS;
   localparam int CMP_BITS  = (DVS_BITS > POS_BITS) ? DVS_BITS : POS_BITS;
   localparam int WIDE_BITS = (COORD_BITS + 1 > PROC_BITS) ? COORD_BITS + 1 : PROC_BITS;
   localparam int PROD_BITS = POS_BITS + COORD_BITS;

   // Reciprocal of MIN_POINTS, exact for every coordinate-wide dividend
   localparam int MIN_LOG     = $clog2(MIN_POINTS);
   localparam int RECIP_SHIFT = COORD_BITS + MIN_LOG;
   localparam int MDIV_BITS   = RECIP_SHIFT + COORD_BITS;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + 64'(MIN_POINTS) - 64'd1) / 64'(MIN_POINTS);

   logic [PROC_BITS-1:0]  procs_ff [3];
   logic [POS_BITS-1:0]   pos_ff [3];
   req_payload_type       item_ff;
   logic [PROC_BITS-1:0]  cnt_ff [3];
   logic [PROC_BITS-1:0]  cnt_in [3];
   logic [COORD_BITS-1:0] prev_begin_ff [3];
   logic [COORD_BITS-1:0] prev_end_ff [3];
   logic [COORD_BITS-1:0] prev_size_ff [3];
   logic [PROC_BITS-1:0]  prev_cnt_ff [3];

   logic [COORD_BITS-1:0] size_a [3];
   logic [COORD_BITS-1:0] flo_a [3];
   logic [COORD_BITS-1:0] fhi_a [3];
   logic [COORD_BITS-1:0] quo_a [3];
   logic [DVS_BITS-1:0]   rem_a [3];
   logic [2:0]            done_a;
   logic [2:0]            pos_ok;

   logic [COORD_BITS-1:0] n_ff, prod_ff, radd_ff;
   logic [COORD_BITS-1:0] b_ff, e_ff, b_in, e_in;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_ff, rsp_in;

   logic                  active_w;
   logic [COORD_BITS-1:0] q_sel, size_sel, flo_sel, fhi_sel;
   logic [DVS_BITS-1:0]   r_sel;
   logic [POS_BITS-1:0]   pos_sel;
   logic                  pos_lt_r;
   logic [COORD_BITS-1:0] n_w;
   logic [PROD_BITS-1:0]  prod_full;
   logic                  split_w;
   logic [COORD_BITS-1:0] split_b, split_e, half_b, half_e;
   logic [COORD_BITS-1:0] fb_w, fe_w;

   assign size_a = '{item_ff.size_x, item_ff.size_y, item_ff.size_z};
   assign flo_a  = '{item_ff.finer_lo_x, item_ff.finer_lo_y, item_ff.finer_lo_z};
   assign fhi_a  = '{item_ff.finer_hi_x, item_ff.finer_hi_y, item_ff.finer_hi_z};

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < 3; d++) begin
            procs_ff[d] <= PROC_BITS'(1);
            pos_ff[d]   <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_PROCS_X: procs_ff[0] <= csr_wdata[PROC_BITS-1:0];
            CSR_PROCS_Y: procs_ff[1] <= csr_wdata[PROC_BITS-1:0];
            CSR_PROCS_Z: procs_ff[2] <= csr_wdata[PROC_BITS-1:0];
            CSR_POS_X:   pos_ff[0]   <= csr_wdata[POS_BITS-1:0];
            CSR_POS_Y:   pos_ff[1]   <= csr_wdata[POS_BITS-1:0];
            CSR_POS_Z:   pos_ff[2]   <= csr_wdata[POS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Capture the level on accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_payload;
      end
   end

   // One lane per dimension: active count, then size by count
   for (genvar d = 0; d < 3; d++) begin : g_lane
      logic [MDIV_BITS-1:0]  mdiv_prod;
      logic [COORD_BITS-1:0] min_quo;
      logic [WIDE_BITS-1:0]  cnt_full;

      mgbd_divider #(
         .DVS_BITS (DVS_BITS)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .start     (cmd.div_start),
         .dividend  (size_a[d]),
         .divisor   (cnt_ff[d]),
         .done      (done_a[d]),
         .quotient  (quo_a[d]),
         .remainder (rem_a[d])
      );

      // Active count is the smaller of size/MIN_POINTS+1 and the process grid;
      // size/MIN_POINTS comes from a reciprocal multiply and shift
      assign mdiv_prod = MDIV_BITS'(size_a[d]) * MDIV_BITS'(RECIP);
      assign min_quo   = mdiv_prod[RECIP_SHIFT +: COORD_BITS];
      assign cnt_full  = WIDE_BITS'(min_quo) + WIDE_BITS'(1);
      assign cnt_in[d] = (cnt_full > WIDE_BITS'(procs_ff[d])) ? procs_ff[d]
                                                               : cnt_full[PROC_BITS-1:0];

      assign pos_ok[d] = CMP_BITS'(pos_ff[d]) < CMP_BITS'(cnt_ff[d]);
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_store) begin
         cnt_ff <= cnt_in;
      end
   end

   assign active_w = &pos_ok;

   // Select the current dimension
   assign q_sel    = quo_a[cmd.dim];
   assign r_sel    = rem_a[cmd.dim];
   assign pos_sel  = pos_ff[cmd.dim];
   assign size_sel = size_a[cmd.dim];
   assign flo_sel  = flo_a[cmd.dim];
   assign fhi_sel  = fhi_a[cmd.dim];

   // Even split: n points here, begin at pos*n plus the extra points before
   assign pos_lt_r  = CMP_BITS'(pos_sel) < CMP_BITS'(r_sel);
   assign n_w       = q_sel + COORD_BITS'(pos_lt_r);
   assign prod_full = PROD_BITS'(pos_sel) * PROD_BITS'(n_w);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         n_ff    <= n_w;
         prod_ff <= prod_full[COORD_BITS-1:0];
         radd_ff <= pos_lt_r ? '0 : COORD_BITS'(r_sel);
      end
   end

   // Pick the range: zero when inactive, even split, or halved history
   always_comb begin
      split_w = item_ff.first_level || (cnt_ff[cmd.dim] != prev_cnt_ff[cmd.dim]);
      split_b = prod_ff + radd_ff;
      split_e = split_b + n_ff;
      half_b  = (prev_begin_ff[cmd.dim] == '0) ? '0
              : (prev_begin_ff[cmd.dim] >> 1) + flo_sel;
      half_e  = (prev_end_ff[cmd.dim] == prev_size_ff[cmd.dim]) ? size_sel
              : (prev_end_ff[cmd.dim] >> 1) + flo_sel;
      if (!active_w) begin
         b_in = '0;
         e_in = '0;
      end else if (split_w) begin
         b_in = split_b;
         e_in = split_e;
      end else begin
         b_in = half_b;
         e_in = half_e;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         b_ff <= b_in;
         e_ff <= e_in;
      end
   end

   // Clamp to the finer region, lower bound first; zero on the first level
   // and for an inactive process
   always_comb begin
      if (item_ff.first_level || !active_w) begin
         fb_w = '0;
         fe_w = '0;
      end else begin
         fb_w = (b_ff < flo_sel) ? flo_sel : ((b_ff > fhi_sel) ? fhi_sel : b_ff);
         fe_w = (e_ff < flo_sel) ? flo_sel : ((e_ff > fhi_sel) ? fhi_sel : e_ff);
      end
      rsp_in.dim               = cmd.dim;
      rsp_in.last              = (cmd.dim == DIM_Z);
      rsp_in.active            = active_w;
      rsp_in.local_begin       = b_ff;
      rsp_in.local_end         = e_ff;
      rsp_in.local_size        = e_ff - b_ff;
      rsp_in.local_finer_begin = fb_w;
      rsp_in.local_finer_end   = fe_w;
      rsp_in.local_finer_size  = fe_w - fb_w;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // Record this level's range, size and count for the next level
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < 3; d++) begin
            prev_begin_ff[d] <= '0;
            prev_end_ff[d]   <= '0;
            prev_size_ff[d]  <= '0;
            prev_cnt_ff[d]   <= '0;
         end
      end else if (cmd.emit) begin
         prev_begin_ff[cmd.dim] <= b_ff;
         prev_end_ff[cmd.dim]   <= e_ff;
         prev_size_ff[cmd.dim]  <= size_sel;
         prev_cnt_ff[cmd.dim]   <= cnt_ff[cmd.dim];
      end
   end

   assign status.div_done  = &done_a;
   assign status.slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_ff;

   `MGBD_ASSERT_SAME(a_emit_slot, cmd.emit, !rsp_valid_ff || rsp_ready,
      "result overwritten before it was taken")
   `MGBD_ASSERT_SAME(a_inactive_zero, rsp_valid_ff && !rsp_ff.active,
      rsp_ff.local_begin == '0 && rsp_ff.local_end == '0 && rsp_ff.local_finer_begin == '0,
      "inactive result carries a nonzero range")

endmodule

// ===== design/multigrid_block_decomposer.sv =====
// ----------------------------------------------------------------------------
// Multigrid block decomposer
// Per-process 3D block decomposition of a multigrid hierarchy, one level
// per transaction, three result transactions (x, y, z) per level.
// ----------------------------------------------------------------------------
// A level runs from accept through its x, y and z results, and levels do not
// overlap. The main step is one pass of three bit-serial dividers, one lane
// per dimension, computing size / count for the even split; the active
// counts come from a constant reciprocal multiply the cycle after accept,
// and a multiply, sum and emit stage follow for each dimension. A result
// that is not taken holds the block in its emit stage. Results sit in an
// output register, so the next level is accepted as soon as the z result
// is loaded. Write the csr_ registers only while no level is in flight;
// they reset to a 1x1x1 grid at position zero.
module multigrid_block_decomposer import mgbd_pkg::*; #(
   parameter int PROC_BITS  = 11,
   parameter int MIN_POINTS = 5,
   parameter int CSR_BITS   = (PROC_BITS > 10) ? PROC_BITS : 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]       csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequence the level
   mgbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Compute the ranges
   mgbd_datapath #(
      .PROC_BITS  (PROC_BITS),
      .MIN_POINTS (MIN_POINTS),
      .CSR_BITS   (CSR_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multigrid block decomposer testbench
// Drives multigrid levels through the request channel and checks every x, y
// and z range transaction against a cycle-free prediction of the per-process
// decomposition. Covers the reset state, even split and halving paths,
// inactive processes, grid extremes, output backpressure and random level
// sequences under several process-grid settings.
// ----------------------------------------------------------------------------
module tb_top import mgbd_pkg::*; ();

   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 11;
   localparam int MIN_POINTS      = 5;
   localparam int CSR_W           = 11;
   localparam int MAX_IDLE        = 19;
   localparam int LEVEL_LATENCY   = 60;
   localparam int SETTLE_CYCLES   = 4;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_LEVELS   = 208;
   localparam int PHASE_LEVELS    = 40;
   localparam int HOLD_OFF_CYCLES = 300;

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_W-1:0]          csr_wdata;
   logic                      req_valid;
   logic                      req_ready;
   req_payload_type           req_payload;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_payload_type           rsp_payload;

   // Predicted configuration and per-dimension history
   logic [CSR_W-1:0]      grid_procs [3];
   logic [POS_BITS-1:0]   grid_pos [3];
   logic [COORD_BITS-1:0] prior_begin [3];
   logic [COORD_BITS-1:0] prior_end [3];
   logic [COORD_BITS-1:0] prior_size [3];
   logic [CSR_W-1:0]      prior_count [3];
   rsp_payload_type       expected_ranges [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int rx_hold_cycles = 0;
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;

   multigrid_block_decomposer DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Free-running clock
   initial clock = 1'b0;
   always #(CLOCK_HALF) clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d ranges pending", $time, expected_ranges.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [COORD_BITS-1:0] clamp_to_region(logic [COORD_BITS-1:0] v,
                                                             logic [COORD_BITS-1:0] lo,
                                                             logic [COORD_BITS-1:0] hi);
      // lower bound is checked first, which matters when the region is inverted
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Work out the three range transactions of one level and advance the history
   function automatic void predict_level(req_payload_type lv);
      logic [COORD_BITS-1:0] sz [3];
      logic [COORD_BITS-1:0] flo [3];
      logic [COORD_BITS-1:0] fhi [3];
      logic [COORD_BITS-1:0] b [3];
      logic [COORD_BITS-1:0] e [3];
      logic [COORD_BITS-1:0] fb [3];
      logic [COORD_BITS-1:0] fe [3];
      logic [DIM_BITS-1:0]   dim_code [3];
      longint unsigned       cnt [3];
      longint unsigned       quo, rem, share, start;
      bit                    all_active;
      rsp_payload_type       res;

      sz[0]  = lv.size_x;     sz[1]  = lv.size_y;     sz[2]  = lv.size_z;
      flo[0] = lv.finer_lo_x; flo[1] = lv.finer_lo_y; flo[2] = lv.finer_lo_z;
      fhi[0] = lv.finer_hi_x; fhi[1] = lv.finer_hi_y; fhi[2] = lv.finer_hi_z;
      dim_code[0] = DIM_X;    dim_code[1] = DIM_Y;    dim_code[2] = DIM_Z;

      // active count per dimension; one short dimension idles the process
      all_active = 1'b1;
      for (int d = 0; d < 3; d++) begin
         cnt[d] = sz[d] / MIN_POINTS + 1;
         if (cnt[d] > grid_procs[d]) cnt[d] = grid_procs[d];
         if (grid_pos[d] >= cnt[d]) all_active = 1'b0;
      end

      for (int d = 0; d < 3; d++) begin
         b[d] = '0; e[d] = '0; fb[d] = '0; fe[d] = '0;
         if (all_active) begin
            if (lv.first_level || cnt[d] != prior_count[d]) begin
               // even split, remainder to the lowest positions
               quo   = sz[d] / cnt[d];
               rem   = sz[d] % cnt[d];
               share = quo + ((grid_pos[d] < rem) ? 1 : 0);
               start = grid_pos[d] * share + ((grid_pos[d] >= rem) ? rem : 0);
               b[d]  = COORD_BITS'(start);
               e[d]  = COORD_BITS'(start + share);
            end else begin
               // halve the previous range and shift by the finer begin
               b[d] = (prior_begin[d] == '0) ? '0 : prior_begin[d] / 2 + flo[d];
               e[d] = (prior_end[d] == prior_size[d]) ? sz[d] : prior_end[d] / 2 + flo[d];
            end
            if (!lv.first_level) begin
               fb[d] = clamp_to_region(b[d], flo[d], fhi[d]);
               fe[d] = clamp_to_region(e[d], flo[d], fhi[d]);
            end
         end
      end

      for (int d = 0; d < 3; d++) begin
         res.dim               = dim_code[d];
         res.last              = (d == 2);
         res.active            = all_active;
         res.local_begin       = b[d];
         res.local_end         = e[d];
         res.local_size        = e[d] - b[d];
         res.local_finer_begin = fb[d];
         res.local_finer_end   = fe[d];
         res.local_finer_size  = fe[d] - fb[d];
         expected_ranges.insert(expected_ranges.size(), res);
         prior_begin[d] = b[d];
         prior_end[d]   = e[d];
         prior_size[d]  = sz[d];
         prior_count[d] = CSR_W'(cnt[d]);
      end
   endfunction

   function automatic void compare_field(string name, logic [COORD_BITS-1:0] want,
                                         logic [COORD_BITS-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Check each accepted range transaction against the oldest prediction
   always @(posedge clock) begin : range_check
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_ranges.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected range, expected nothing, actual %p", $time, rsp_payload);
         end else begin
            want = expected_ranges.pop_front();
            compare_field("dim", want.dim, rsp_payload.dim);
            compare_field("last", want.last, rsp_payload.last);
            compare_field("active", want.active, rsp_payload.active);
            compare_field("local_begin", want.local_begin, rsp_payload.local_begin);
            compare_field("local_end", want.local_end, rsp_payload.local_end);
            compare_field("local_size", want.local_size, rsp_payload.local_size);
            compare_field("local_finer_begin", want.local_finer_begin,
                          rsp_payload.local_finer_begin);
            compare_field("local_finer_end", want.local_finer_end,
                          rsp_payload.local_finer_end);
            compare_field("local_finer_size", want.local_finer_size,
                          rsp_payload.local_finer_size);
         end
      end
   end

   // Result side: random stalls, plus a long hold-off on request
   initial begin : range_sink
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rx_hold_cycles) @(posedge clock);
            rx_hold_cycles = 0;
         end
         stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Offer one level; valid stays up if the next level follows without a gap
   task automatic send_level(req_payload_type lv);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= lv;
      do @(posedge clock); while (!req_ready);
      predict_level(lv);
   endtask

   // Drop valid and hold until every predicted range has come back
   task automatic drain_ranges();
      if (req_valid) req_valid <= 1'b0;
      while (expected_ranges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all six registers back to back; the block must be idle
   task automatic apply_grid(int px, int py, int pz, int qx, int qy, int qz);
      logic [CSR_INDEX_BITS-1:0] reg_index [6];
      int                        reg_value [6];
      reg_index[0] = CSR_PROCS_X; reg_value[0] = px;
      reg_index[1] = CSR_PROCS_Y; reg_value[1] = py;
      reg_index[2] = CSR_PROCS_Z; reg_value[2] = pz;
      reg_index[3] = CSR_POS_X;   reg_value[3] = qx;
      reg_index[4] = CSR_POS_Y;   reg_value[4] = qy;
      reg_index[5] = CSR_POS_Z;   reg_value[5] = qz;
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= reg_index[i];
         csr_wdata <= CSR_W'(reg_value[i]);
         @(posedge clock);
         case (reg_index[i])
            CSR_PROCS_X: grid_procs[0] = CSR_W'(reg_value[i]);
            CSR_PROCS_Y: grid_procs[1] = CSR_W'(reg_value[i]);
            CSR_PROCS_Z: grid_procs[2] = CSR_W'(reg_value[i]);
            CSR_POS_X:   grid_pos[0] = POS_BITS'(reg_value[i]);
            CSR_POS_Y:   grid_pos[1] = POS_BITS'(reg_value[i]);
            CSR_POS_Z:   grid_pos[2] = POS_BITS'(reg_value[i]);
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   function automatic req_payload_type level(bit first, int sx, int sy, int sz,
                                             int lx, int ly, int lz,
                                             int hx, int hy, int hz);
      req_payload_type lv;
      lv.first_level = first;
      lv.size_x = COORD_BITS'(sx);     lv.size_y = COORD_BITS'(sy);
      lv.size_z = COORD_BITS'(sz);
      lv.finer_lo_x = COORD_BITS'(lx); lv.finer_lo_y = COORD_BITS'(ly);
      lv.finer_lo_z = COORD_BITS'(lz);
      lv.finer_hi_x = COORD_BITS'(hx); lv.finer_hi_y = COORD_BITS'(hy);
      lv.finer_hi_z = COORD_BITS'(hz);
      return lv;
   endfunction

   // Small, wide and full-range sizes, and some near the top of the range, in equal shares
   function automatic int draw_size();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 40);
         1:       return $urandom_range(41, 1000);
         2:       return $urandom_range(0, 65535);
         default: return $urandom_range(60000, 65535);
      endcase
   endfunction

   // Finer region inside the level, now and then inverted
   function automatic void draw_region(int s, output int lo, output int hi);
      int swap;
      lo = $urandom_range(0, s / 2);
      hi = $urandom_range(lo, s);
      if ($urandom_range(0, 7) == 0) begin
         swap = lo; lo = hi; hi = swap;
      end
   endfunction

   function automatic req_payload_type build_level(bit first, int sx, int sy, int sz);
      int lx, ly, lz, hx, hy, hz;
      draw_region(sx, lx, hx);
      draw_region(sy, ly, hy);
      draw_region(sz, lz, hz);
      return level(first, sx, sy, sz, lx, ly, lz, hx, hy, hz);
   endfunction

   function automatic req_payload_type noise_level();
      return level($urandom_range(0, 1),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
   endfunction

   function automatic int draw_procs();
      case ($urandom_range(0, 9))
         0:          return 1;
         1, 2, 3, 4: return $urandom_range(1, 8);
         5, 6:       return $urandom_range(9, 64);
         7:          return 1024;
         8:          return $urandom_range(65, 1024);
         default:    return $urandom_range(0, 2047);
      endcase
   endfunction

   function automatic int draw_pos(int procs);
      if (procs == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 1023);
      return $urandom_range(0, (procs > 1024) ? 1023 : procs - 1);
   endfunction

   task automatic apply_random_grid();
      int px, py, pz;
      px = draw_procs();
      py = draw_procs();
      pz = draw_procs();
      apply_grid(px, py, pz, draw_pos(px), draw_pos(py), draw_pos(pz));
   endtask

   // Default 1x1x1 grid: coarse level straight after reset, full sizes,
   // inverted finer regions on the halving path
   task automatic test_reset_state();
      send_level(level(0, 100, 0, 65535, 10, 0, 5, 90, 0, 65535));
      send_level(level(1, 65535, 65535, 65535, 0, 0, 0, 65535, 65535, 65535));
      send_level(level(0, 32767, 32768, 1, 65535, 65535, 0, 0, 0, 0));
      send_level(level(0, 16383, 16384, 0, 100, 200, 300, 50, 60, 70));
      drain_ranges();
   endtask

   // 4x3x2 grid: remainder split, halving, wrap, count change, inactive level
   task automatic test_split_and_halving();
      apply_grid(4, 3, 2, 3, 1, 1);
      send_level(level(1, 103, 61, 40, 0, 0, 0, 103, 61, 40));
      send_level(level(0, 52, 31, 20, 10, 5, 3, 40, 25, 60));
      send_level(level(0, 26, 16, 10, 65535, 65535, 65535, 65535, 65535, 65535));
      send_level(level(0, 13, 8, 5, 2, 1, 0, 11, 7, 4));
      send_level(level(0, 3, 3, 3, 0, 0, 0, 3, 3, 3));
      send_level(level(0, 52, 31, 20, 4, 4, 4, 30, 20, 10));
      drain_ranges();
   endtask

   // 1024-cube grid at the largest position, zero processes, all-ones register values
   task automatic test_grid_extremes();
      apply_grid(1024, 1024, 1024, 1023, 1023, 1023);
      send_level(level(1, 65535, 65535, 65535, 0, 0, 0, 65535, 65535, 65535));
      send_level(level(0, 32767, 32767, 32767, 100, 0, 65535, 30000, 65535, 0));
      drain_ranges();
      apply_grid(0, 1, 1, 0, 0, 0);
      send_level(level(1, 1000, 1000, 1000, 0, 0, 0, 1000, 1000, 1000));
      send_level(level(0, 500, 500, 500, 10, 10, 10, 400, 400, 400));
      drain_ranges();
      apply_grid(2047, 1, 1, 1023, 0, 0);
      send_level(level(1, 65535, 7, 9, 0, 0, 0, 65535, 7, 9));
      send_level(level(0, 32768, 3, 4, 1, 1, 1, 32000, 2, 3));
      drain_ranges();
   endtask

   // Hold off the result side long enough for the block to stall its input
   task automatic test_output_backpressure();
      int sx, sy, sz;
      apply_grid(2, 2, 2, 1, 0, 1);
      tx_idle_on = 1'b0;
      rx_hold_cycles = HOLD_OFF_CYCLES;
      sx = 400; sy = 250; sz = 90;
      send_level(build_level(1, sx, sy, sz));
      repeat (5) begin
         sx = sx / 2; sy = sy / 2; sz = sz / 2;
         send_level(build_level(0, sx, sy, sz));
      end
      drain_ranges();
      tx_idle_on = 1'b1;
   endtask

   // Mostly well-formed hierarchies (finest first, then coarsening), with
   // stray levels mixed in; new grid and idle pattern every phase
   task automatic test_random_levels();
      int sent, phase, phase_end, depth;
      int sx, sy, sz;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_LEVELS) begin
         drain_ranges();
         apply_random_grid();
         tx_idle_on = (phase % 4) < 2;
         rx_idle_on = (phase % 2) == 0;
         phase_end  = sent + PHASE_LEVELS;
         while (sent < phase_end && sent < RANDOM_LEVELS) begin
            if ($urandom_range(0, 7) == 0) begin
               send_level(noise_level());
               sent++;
            end else begin
               sx = draw_size(); sy = draw_size(); sz = draw_size();
               send_level(build_level(1, sx, sy, sz));
               sent++;
               depth = $urandom_range(1, 5);
               repeat (depth) begin
                  sx = sx / 2 + $urandom_range(0, 1);
                  sy = sy / 2 + $urandom_range(0, 1);
                  sz = sz / 2 + $urandom_range(0, 1);
                  send_level(build_level(0, sx, sy, sz));
                  sent++;
               end
            end
         end
         phase++;
      end
      drain_ranges();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   initial begin
      reset       <= 1'b1;
      csr_we      <= 1'b0;
      csr_index   <= CSR_PROCS_X;
      csr_wdata   <= '0;
      req_valid   <= 1'b0;
      req_payload <= '0;
      for (int d = 0; d < 3; d++) begin
         grid_procs[d]  = 1;
         grid_pos[d]    = '0;
         prior_begin[d] = '0;
         prior_end[d]   = '0;
         prior_size[d]  = '0;
         prior_count[d] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_split_and_halving();
      test_grid_extremes();
      test_output_backpressure();
      test_random_levels();

      // let any stray transaction show up before the verdict
      repeat (LEVEL_LATENCY) @(posedge clock);
      if (expected_ranges.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d ranges never arrived", $time, expected_ranges.size());
      end
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/mgbd_pkg.sv
design/mgbd_divider.sv
design/mgbd_ctrl.sv
design/mgbd_datapath.sv
design/multigrid_block_decomposer.sv
dv/tb_top.sv
